// ===== design/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and constants shared by the format specifier parser modules.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Parser phases. Within one character the parser only ever moves to a
  // phase later in this list, so one ordered pass covers every chain.
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_IDX_START,
    PH_IDX_NUM,
    PH_AFTER_IDX,
    PH_FAST,
    PH_FILL,
    PH_FILL_ALIGN,
    PH_ALIGN,
    PH_FLAGS,
    PH_WIDTH,
    PH_WIDTH_NUM,
    PH_WIDTH_STAR,
    PH_WIDTH_IDX,
    PH_PREC_CHECK,
    PH_PREC,
    PH_PREC_DOT,
    PH_PREC_NUM,
    PH_PREC_STAR,
    PH_PREC_IDX,
    PH_TYPE,
    PH_SKIP
  } phase_e;

  // Record status codes
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOT_SPEC = 2'd2;

  // Alignment codes
  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  // Flag masks
  localparam logic [6:0] FLG_ALT      = 7'h01;
  localparam logic [6:0] FLG_UPPER    = 7'h02;
  localparam logic [6:0] FLG_ZERO     = 7'h04;
  localparam logic [6:0] FLG_SIGN     = 7'h08;
  localparam logic [6:0] FLG_SPACE    = 7'h10;
  localparam logic [6:0] FLG_WIDTH_IX = 7'h20;
  localparam logic [6:0] FLG_PREC_IX  = 7'h40;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [7:0] MAX_ARGS_RESET = 8'd16;

  // One input character
  typedef struct packed {
    logic [7:0] ch;
    logic       starts_spec;
    logic       new_string;
  } in_t;

  // One parsed record
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  arg_slot;
    logic [6:0]  flag_bits;
    logic [15:0] width_value;
    logic [15:0] precision_value;
    logic [1:0]  alignment;
    logic [7:0]  fill;
    logic [11:0] type_offset;
    logic [11:0] type_length;
    logic [11:0] consumed;
    logic [8:0]  args_referenced;
    logic [7:0]  next_implicit;
  } out_t;

  // Fixed-width parser state
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  slot;
    logic [6:0]  flags;
    logic [15:0] width;
    logic [15:0] prec;
    logic [1:0]  align;
    logic [7:0]  fill;
    logic [7:0]  pend;
    logic [7:0]  cna;
    logic [8:0]  cac;
    logic        bseen;
  } spec_t;

endpackage

// ===== design/fsp_core.sv =====
// ----------------------------------------------------------------------------
// fsp_core
// Single-character parse step: next parser state and the optional record.
// ----------------------------------------------------------------------------
module fsp_core #(
  parameter int unsigned POS_BITS = 12,
  parameter int unsigned NUM_BITS = 16
) (
  input  fsp_pkg::in_t          in_i,
  input  logic [7:0]            max_args_i,
  input  fsp_pkg::spec_t        spec_i,
  input  logic [POS_BITS-1:0]   pos_i,
  input  logic [POS_BITS-1:0]   tst_i,
  input  logic [POS_BITS-1:0]   bpos_i,
  input  logic [NUM_BITS-1:0]   acc_i,
  output fsp_pkg::spec_t        spec_o,
  output logic [POS_BITS-1:0]   pos_o,
  output logic [POS_BITS-1:0]   tst_o,
  output logic [POS_BITS-1:0]   bpos_o,
  output logic [NUM_BITS-1:0]   acc_o,
  output logic                  emit_o,
  output fsp_pkg::out_t         res_o
);

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
    return (p == {POS_BITS{1'b1}}) ? p : p + POS_BITS'(1);
  endfunction

  function automatic logic [11:0] to12(input logic [POS_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[11:0];
  endfunction

  logic [7:0]          c;
  logic                is_dig, is_alph, is_algn;
  logic [3:0]          dval;
  logic [NUM_BITS+3:0] acc_wide;
  logic [NUM_BITS-1:0] acc_first, acc_add;
  logic [31:0]         acc32;
  logic [15:0]         acc_cap16;
  logic [7:0]          acc_sat8;

  // digit accumulate: a*10 + d as shift-add, saturating
  always_comb begin
    c         = in_i.ch;
    is_dig    = (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
    is_alph   = ((c >= fsp_pkg::CH_LO_A) && (c <= fsp_pkg::CH_LO_Z)) ||
                ((c >= fsp_pkg::CH_UP_A) && (c <= fsp_pkg::CH_UP_Z));
    is_algn   = (c == fsp_pkg::CH_LT) || (c == fsp_pkg::CH_CARET) ||
                (c == fsp_pkg::CH_GT);
    dval      = 4'(c - fsp_pkg::CH_ZERO);
    acc_first = {{(NUM_BITS-4){1'b0}}, dval};
    acc_wide  = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} +
                {{NUM_BITS{1'b0}}, dval};
    acc_add   = (acc_wide[NUM_BITS+3:NUM_BITS] != 4'd0) ? {NUM_BITS{1'b1}}
                                                        : acc_wide[NUM_BITS-1:0];
    acc32     = 32'(acc_i);
    acc_cap16 = (acc32[31:16] != 16'd0) ? 16'hFFFF : acc32[15:0];
    acc_sat8  = (acc32[31:8] != 24'd0) ? 8'hFF : acc32[7:0];
  end

  fsp_pkg::spec_t      s;
  logic [POS_BITS-1:0] pos, tst, bpos, plain_cons;
  logic [NUM_BITS-1:0] acc;
  logic                run, adv, fail_now, valid_now, plain_now, emit;
  logic [1:0]          plain_st;
  logic [15:0]         top;
  logic [16:0]         cand;
  logic [31:0]         len_w;
  fsp_pkg::out_t       res;

  always_comb begin
    s          = spec_i;
    pos        = pos_i;
    tst        = tst_i;
    bpos       = bpos_i;
    acc        = acc_i;
    run        = 1'b0;
    adv        = 1'b0;
    fail_now   = 1'b0;
    valid_now  = 1'b0;
    plain_now  = 1'b0;
    plain_st   = fsp_pkg::ST_INVALID;
    plain_cons = '0;
    emit       = 1'b0;
    top        = '0;
    cand       = '0;
    len_w      = '0;
    res        = '0;

    if (in_i.new_string) begin
      s.cna   = '0;
      s.cac   = '0;
      s.phase = fsp_pkg::PH_IDLE;
    end

    if (in_i.starts_spec) begin
      pos     = '0;
      acc     = '0;
      s.slot  = '0;
      s.flags = '0;
      s.width = '0;
      s.prec  = '0;
      s.align = fsp_pkg::ALIGN_LEFT;
      s.fill  = fsp_pkg::CH_SPACE;
      tst     = '0;
      s.pend  = s.cna;
      s.bseen = 1'b0;
      bpos    = '0;
      if (c != fsp_pkg::CH_LBRACE) begin
        plain_now = 1'b1;
        plain_st  = fsp_pkg::ST_NOT_SPEC;
      end else begin
        s.phase = fsp_pkg::PH_IDX_START;
        pos     = POS_BITS'(1);
      end
    end else begin
      run = (s.phase != fsp_pkg::PH_IDLE);
    end

    // Ordered pass: each block may hand over to a later phase.
    if (run && s.phase == fsp_pkg::PH_IDX_START) begin
      if (c == fsp_pkg::CH_RBRACE) begin
        tst = pos; valid_now = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1; run = 1'b0;
      end else if (is_dig) begin
        acc = acc_first; s.phase = fsp_pkg::PH_IDX_NUM; adv = 1'b1; run = 1'b0;
      end else if (s.pend >= max_args_i) begin
        fail_now = 1'b1; run = 1'b0;
      end else begin
        s.slot  = s.pend;
        s.pend  = s.pend + 8'd1;
        s.phase = fsp_pkg::PH_AFTER_IDX;
      end
    end

    if (run && s.phase == fsp_pkg::PH_IDX_NUM) begin
      if (is_dig) begin
        acc = acc_add; adv = 1'b1; run = 1'b0;
      end else begin
        s.slot = acc_sat8;
        if (s.slot >= max_args_i) begin
          fail_now = 1'b1; run = 1'b0;
        end else begin
          s.phase = fsp_pkg::PH_AFTER_IDX;
        end
      end
    end

    if (run && s.phase == fsp_pkg::PH_AFTER_IDX) begin
      run = 1'b0;
      if (c == fsp_pkg::CH_RBRACE) begin
        tst = pos; valid_now = 1'b1;
      end else if (c == fsp_pkg::CH_COLON) begin
        s.phase = fsp_pkg::PH_FAST; adv = 1'b1;
      end else begin
        fail_now = 1'b1;
      end
    end

    if (run && s.phase == fsp_pkg::PH_FAST) begin
      if (is_alph || c == fsp_pkg::CH_RBRACE) begin
        tst = pos; s.phase = fsp_pkg::PH_TYPE;
      end else if (c == fsp_pkg::CH_ZERO) begin
        s.phase = fsp_pkg::PH_FLAGS;
      end else if (is_dig) begin
        s.phase = fsp_pkg::PH_WIDTH;
      end else if (c == fsp_pkg::CH_DOT) begin
        s.phase = fsp_pkg::PH_PREC;
      end else if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_DOLLAR) begin
        s.phase = fsp_pkg::PH_FILL; adv = 1'b1; run = 1'b0;
      end else begin
        s.phase = fsp_pkg::PH_ALIGN;
      end
    end

    if (run && s.phase == fsp_pkg::PH_FILL) begin
      run = 1'b0;
      if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1;
      end else begin
        s.fill = c;
        if (c == fsp_pkg::CH_RBRACE) begin
          s.bseen = 1'b1; bpos = pos;
        end
        s.phase = fsp_pkg::PH_FILL_ALIGN;
        adv     = 1'b1;
      end
    end

    if (run && s.phase == fsp_pkg::PH_FILL_ALIGN) begin
      if (!is_algn) begin
        fail_now = 1'b1; run = 1'b0;
      end else begin
        s.phase = fsp_pkg::PH_ALIGN;
      end
    end

    if (run && s.phase == fsp_pkg::PH_ALIGN) begin
      s.phase = fsp_pkg::PH_FLAGS;
      if (c == fsp_pkg::CH_LT) begin
        s.align = fsp_pkg::ALIGN_LEFT; adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_CARET) begin
        s.align = fsp_pkg::ALIGN_CENTER; adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_GT) begin
        s.align = fsp_pkg::ALIGN_RIGHT; adv = 1'b1; run = 1'b0;
      end
    end

    if (run && s.phase == fsp_pkg::PH_FLAGS) begin
      if (c == fsp_pkg::CH_HASH) begin
        s.flags = s.flags | fsp_pkg::FLG_ALT; adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_BANG) begin
        s.flags = s.flags | fsp_pkg::FLG_UPPER; adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_ZERO) begin
        s.flags = s.flags | fsp_pkg::FLG_ZERO;
        s.fill  = fsp_pkg::CH_ZERO;
        adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_PLUS) begin
        s.flags = s.flags | fsp_pkg::FLG_SIGN; adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_SPACE) begin
        s.flags = s.flags | fsp_pkg::FLG_SPACE; adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_RBRACE) begin
        tst = pos; s.phase = fsp_pkg::PH_TYPE;
      end else if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1; run = 1'b0;
      end else begin
        s.phase = fsp_pkg::PH_WIDTH;
      end
    end

    if (run && s.phase == fsp_pkg::PH_WIDTH) begin
      if (is_dig) begin
        acc = acc_first; s.phase = fsp_pkg::PH_WIDTH_NUM; adv = 1'b1; run = 1'b0;
      end else if (c == fsp_pkg::CH_STAR) begin
        s.phase = fsp_pkg::PH_WIDTH_STAR; adv = 1'b1; run = 1'b0;
      end else begin
        s.phase = fsp_pkg::PH_PREC_CHECK;
      end
    end

    if (run && s.phase == fsp_pkg::PH_WIDTH_NUM) begin
      if (is_dig) begin
        acc = acc_add; adv = 1'b1; run = 1'b0;
      end else begin
        s.width = acc_cap16; s.phase = fsp_pkg::PH_PREC_CHECK;
      end
    end

    if (run && s.phase == fsp_pkg::PH_WIDTH_STAR) begin
      if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1; run = 1'b0;
      end else if (is_dig) begin
        acc = acc_first; s.phase = fsp_pkg::PH_WIDTH_IDX; adv = 1'b1; run = 1'b0;
      end else if (s.pend >= max_args_i) begin
        fail_now = 1'b1; run = 1'b0;
      end else begin
        s.width = {8'd0, s.pend};
        s.pend  = s.pend + 8'd1;
        s.flags = s.flags | fsp_pkg::FLG_WIDTH_IX;
        s.phase = fsp_pkg::PH_PREC_CHECK;
      end
    end

    if (run && s.phase == fsp_pkg::PH_WIDTH_IDX) begin
      if (is_dig) begin
        acc = acc_add; adv = 1'b1; run = 1'b0;
      end else begin
        s.width = acc_cap16;
        s.flags = s.flags | fsp_pkg::FLG_WIDTH_IX;
        if (s.width >= {8'd0, max_args_i}) begin
          fail_now = 1'b1; run = 1'b0;
        end else begin
          s.phase = fsp_pkg::PH_PREC_CHECK;
        end
      end
    end

    if (run && s.phase == fsp_pkg::PH_PREC_CHECK) begin
      if (c == fsp_pkg::CH_RBRACE) begin
        tst = pos; s.phase = fsp_pkg::PH_TYPE;
      end else if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1; run = 1'b0;
      end else begin
        s.phase = fsp_pkg::PH_PREC;
      end
    end

    if (run && s.phase == fsp_pkg::PH_PREC) begin
      if (c == fsp_pkg::CH_DOT) begin
        s.phase = fsp_pkg::PH_PREC_DOT; adv = 1'b1; run = 1'b0;
      end else begin
        tst = pos; s.phase = fsp_pkg::PH_TYPE;
      end
    end

    if (run && s.phase == fsp_pkg::PH_PREC_DOT) begin
      run = 1'b0;
      if (is_dig) begin
        acc = acc_first; s.phase = fsp_pkg::PH_PREC_NUM; adv = 1'b1;
      end else if (c == fsp_pkg::CH_STAR) begin
        s.phase = fsp_pkg::PH_PREC_STAR; adv = 1'b1;
      end else begin
        fail_now = 1'b1;
      end
    end

    if (run && s.phase == fsp_pkg::PH_PREC_NUM) begin
      if (is_dig) begin
        acc = acc_add; adv = 1'b1; run = 1'b0;
      end else begin
        s.prec = acc_cap16; tst = pos; s.phase = fsp_pkg::PH_TYPE;
      end
    end

    if (run && s.phase == fsp_pkg::PH_PREC_STAR) begin
      if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1; run = 1'b0;
      end else if (is_dig) begin
        acc = acc_first; s.phase = fsp_pkg::PH_PREC_IDX; adv = 1'b1; run = 1'b0;
      end else if (s.pend >= max_args_i) begin
        fail_now = 1'b1; run = 1'b0;
      end else begin
        // implicit '*' precision is an argument index
        s.prec  = {8'd0, s.pend};
        s.pend  = s.pend + 8'd1;
        s.flags = s.flags | fsp_pkg::FLG_PREC_IX;
        tst     = pos;
        s.phase = fsp_pkg::PH_TYPE;
      end
    end

    if (run && s.phase == fsp_pkg::PH_PREC_IDX) begin
      if (is_dig) begin
        acc = acc_add; adv = 1'b1; run = 1'b0;
      end else begin
        s.prec  = acc_cap16;
        s.flags = s.flags | fsp_pkg::FLG_PREC_IX;
        if (s.prec >= {8'd0, max_args_i}) begin
          fail_now = 1'b1; run = 1'b0;
        end else begin
          tst = pos; s.phase = fsp_pkg::PH_TYPE;
        end
      end
    end

    if (run && s.phase == fsp_pkg::PH_TYPE) begin
      run = 1'b0;
      if (c == fsp_pkg::CH_RBRACE) begin
        valid_now = 1'b1;
      end else if (c == fsp_pkg::CH_NUL) begin
        fail_now = 1'b1;
      end else begin
        adv = 1'b1;
      end
    end

    if (run && s.phase == fsp_pkg::PH_SKIP) begin
      run = 1'b0;
      if (c == fsp_pkg::CH_RBRACE) begin
        plain_now = 1'b1; plain_cons = sat_inc(pos);
      end else if (c == fsp_pkg::CH_NUL) begin
        plain_now = 1'b1; plain_cons = pos;
      end else begin
        adv = 1'b1;
      end
    end

    // error: close now at a known or current brace or at a NUL, else skip ahead
    if (fail_now) begin
      if (s.bseen) begin
        plain_now = 1'b1; plain_cons = sat_inc(bpos);
      end else if (c == fsp_pkg::CH_RBRACE) begin
        plain_now = 1'b1; plain_cons = sat_inc(pos);
      end else if (c == fsp_pkg::CH_NUL) begin
        plain_now = 1'b1; plain_cons = pos;
      end else begin
        s.phase = fsp_pkg::PH_SKIP;
        adv     = 1'b1;
      end
    end

    if (adv) begin
      pos = sat_inc(pos);
    end

    if (valid_now) begin
      top = {8'd0, s.slot};
      if (((s.flags & fsp_pkg::FLG_WIDTH_IX) != '0) && (s.width > top)) begin
        top = s.width;
      end
      if (((s.flags & fsp_pkg::FLG_PREC_IX) != '0) && (s.prec > top)) begin
        top = s.prec;
      end
      cand = {1'b0, top} + 17'd1;
      if (cand > {8'd0, s.cac}) begin
        s.cac = cand[8:0];
      end
      s.cna   = s.pend;
      len_w   = 32'(pos) - 32'(tst);
      res.status          = fsp_pkg::ST_VALID;
      res.arg_slot        = s.slot;
      res.flag_bits       = s.flags;
      res.width_value     = s.width;
      res.precision_value = s.prec;
      res.alignment       = s.align;
      res.fill            = s.fill;
      res.type_offset     = to12(tst);
      res.type_length     = len_w[11:0];
      res.consumed        = to12(sat_inc(pos));
      res.args_referenced = s.cac;
      res.next_implicit   = s.cna;
      s.phase = fsp_pkg::PH_IDLE;
      emit    = 1'b1;
    end else if (plain_now) begin
      res.status          = plain_st;
      res.consumed        = to12(plain_cons);
      res.args_referenced = s.cac;
      res.next_implicit   = s.cna;
      s.phase = fsp_pkg::PH_IDLE;
      emit    = 1'b1;
    end
  end

  assign spec_o = s;
  assign pos_o  = pos;
  assign tst_o  = tst;
  assign bpos_o = bpos;
  assign acc_o  = acc;
  assign emit_o = emit;
  assign res_o  = res;

endmodule

// ===== design/format_specifier_parser.sv =====
// ----------------------------------------------------------------------------
// format_specifier_parser
// Streaming parser for {[index]:[[$fill]align][flags][width][.precision][type]}
// ----------------------------------------------------------------------------
// Takes one format string character per transfer and returns one record per
// specifier, at its closing brace or at a NUL, or at its first character if
// it is not a specifier: valid (fields, type span, characters consumed),
// invalid (characters to skip) or not a specifier. The implicit argument
// counter and the highest argument referenced are committed only on valid
// specifiers and reported with every record. Throughput is one character per
// clock while no record waits on out_stall_i: a character sits in the input
// register until the parse step updates the parser state and, when the
// character ends a specifier, loads the result register. The loop that fixes
// the rate is the parser state feeding back through the combinational parse
// step (phase walk, decimal shift-add, index compares). A waiting record
// halts the parse step; the input register then takes at most one more
// character and stalls. max_args resets to 16; the user must write it with
// cfg_we_i while no character is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module format_specifier_parser #(
  parameter int unsigned POS_BITS = 12,
  parameter int unsigned NUM_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  // character input
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fsp_pkg::in_t  in_data_i,
  // record output
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fsp_pkg::out_t out_data_o
);

  logic [7:0] max_args_q;

  // input register
  logic         in_vld_q, in_vld_d;
  fsp_pkg::in_t in_q;

  // output register
  logic          out_vld_q, out_vld_d;
  fsp_pkg::out_t out_q;

  // parser state
  fsp_pkg::spec_t      spec_q, spec_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] tst_q, tst_d;
  logic [POS_BITS-1:0] bpos_q, bpos_d;
  logic [NUM_BITS-1:0] acc_q, acc_d;

  logic          emit;
  fsp_pkg::out_t res;
  logic          out_free, step, in_xfer;

  // Result slot is free when empty or its record transfers this cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  // Parse the held character whenever its possible record has a place.
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_xfer || (in_vld_q && !step);
  assign out_vld_d = (step && emit) ? 1'b1 : (out_free ? 1'b0 : out_vld_q);

  fsp_core #(
    .POS_BITS (POS_BITS),
    .NUM_BITS (NUM_BITS)
  ) u_core (
    .in_i       (in_q),
    .max_args_i (max_args_q),
    .spec_i     (spec_q),
    .pos_i      (pos_q),
    .tst_i      (tst_q),
    .bpos_i     (bpos_q),
    .acc_i      (acc_q),
    .spec_o     (spec_d),
    .pos_o      (pos_d),
    .tst_o      (tst_d),
    .bpos_o     (bpos_d),
    .acc_o      (acc_d),
    .emit_o     (emit),
    .res_o      (res)
  );

  // Control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q <= fsp_pkg::MAX_ARGS_RESET;
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      spec_q     <= '{phase: fsp_pkg::PH_IDLE, slot: '0, flags: '0, width: '0,
                      prec: '0, align: fsp_pkg::ALIGN_LEFT,
                      fill: fsp_pkg::CH_SPACE, pend: '0, cna: '0, cac: '0,
                      bseen: 1'b0};
      pos_q      <= '0;
      tst_q      <= '0;
      bpos_q     <= '0;
      acc_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_args_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step) begin
        spec_q <= spec_d;
        pos_q  <= pos_d;
        tst_q  <= tst_d;
        bpos_q <= bpos_d;
        acc_q  <= acc_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (step && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
